// ===== hw/rtl/dfac_pkg.sv =====
package dfac_pkg;

  localparam int unsigned BoxSizeDef       = 20;
  localparam int unsigned BoxOffsetDef     = 20;
  localparam int unsigned CenterBoxSizeDef = 80;
  localparam int unsigned CoordWidthDef    = 11;

  localparam int unsigned SumW  = 40;
  localparam int unsigned CntW  = 24;
  localparam int unsigned AvgW  = 24;
  localparam int unsigned QuoW  = 48;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned DimW  = 12;
  localparam int unsigned DepW  = 16;
  localparam int unsigned DispW = 17;
  localparam int unsigned NumAcc = 5;
  localparam int unsigned AccIdxW = 3;

  // box order in the accumulator bank
  localparam logic [AccIdxW-1:0] AccUpper  = 3'd0;
  localparam logic [AccIdxW-1:0] AccLower  = 3'd1;
  localparam logic [AccIdxW-1:0] AccLeft   = 3'd2;
  localparam logic [AccIdxW-1:0] AccRight  = 3'd3;
  localparam logic [AccIdxW-1:0] AccCenter = 3'd4;

  // configuration register indexes
  localparam logic [2:0] RegFrameWidth  = 3'd0;
  localparam logic [2:0] RegFrameHeight = 3'd1;
  localparam logic [2:0] RegMinDepth    = 3'd2;
  localparam logic [2:0] RegOrientThr   = 3'd3;
  localparam logic [2:0] RegDistTarget  = 3'd4;
  localparam logic [2:0] RegDistTol     = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic             pix_en;    // accumulate current beat
    logic             div_start; // load divider for selected box
    logic [AccIdxW-1:0] div_sel;
    logic             div_step;  // one quotient bit
    logic             avg_store; // keep divider result
    logic             finish;    // form flags and output
    logic             clear;     // clear frame state
  } dfac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dfac_sts_t;

endpackage

// ===== hw/rtl/depth_frame_alignment_checker.sv =====
// channel | ports                                  | direction
// in      | in_valid/in_ready, depth, last_of_frame | pixel beats in
// out     | out_valid/out_ready, disparity, flags   | one result beat per frame
// cfg     | cfg_we, cfg_index, cfg_data            | register writes
// one pixel beat per cycle while a frame streams in and the output is not stalled.
// at frame end the five box sums go in turn through the shared bit-serial divider,
// during which in_ready is low.
// synchronous active-low reset restores register defaults and clears sums.
// the result register holds the beat while out_ready is low; pixels wait meanwhile.
module depth_frame_alignment_checker #(
  parameter int unsigned BOX_SIZE        = dfac_pkg::BoxSizeDef,
  parameter int unsigned BOX_OFFSET      = dfac_pkg::BoxOffsetDef,
  parameter int unsigned CENTER_BOX_SIZE = dfac_pkg::CenterBoxSizeDef,
  parameter int unsigned COORD_WIDTH     = dfac_pkg::CoordWidthDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [dfac_pkg::CfgW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dfac_pkg::DepW-1:0]         in_depth,
  input  logic                              in_last_of_frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dfac_pkg::DispW-1:0] out_horizontal_disparity,
  output logic signed [dfac_pkg::DispW-1:0] out_vertical_disparity,
  output logic                              out_aligned,
  output logic [dfac_pkg::DepW-1:0]         out_center_distance,
  output logic                              out_at_distance
);
  import dfac_pkg::*;

  dfac_cmd_t cmd;
  dfac_sts_t sts;

  dfac_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last_of_frame,
    .out_valid, .out_ready, .cmd, .sts
  );

  dfac_dp #(
    .BOX_SIZE(BOX_SIZE), .BOX_OFFSET(BOX_OFFSET),
    .CENTER_BOX_SIZE(CENTER_BOX_SIZE), .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_depth, .cmd, .sts,
    .out_horizontal_disparity, .out_vertical_disparity, .out_aligned,
    .out_center_distance, .out_at_distance
  );

endmodule

// ===== hw/rtl/dfac_ctrl.sv =====
module dfac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_last_of_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output dfac_pkg::dfac_cmd_t cmd,
  input  dfac_pkg::dfac_sts_t sts
);
  import dfac_pkg::*;

  typedef enum logic [2:0] {
    ST_PIX, ST_LOAD, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t             state_r;
  logic [AccIdxW-1:0] sel_r;
  logic               out_valid_r;

  // accepting pixels; a held output blocks them only while out_ready is low
  assign in_ready  = (state_r == ST_PIX) && !(out_valid_r && !out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      ST_PIX:  cmd.pix_en = in_valid && in_ready;
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV: begin
        cmd.div_step  = !sts.div_done;
        cmd.avg_store = sts.div_done;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        cmd.clear  = 1'b1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIX;
      sel_r       <= AccUpper;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_PIX: begin
          if (in_valid && in_ready && in_last_of_frame) begin
            state_r <= ST_LOAD;
            sel_r   <= AccUpper;
          end
        end
        ST_LOAD: state_r <= ST_DIV;
        ST_DIV: begin
          if (sts.div_done) begin
            if (sel_r == AccCenter) begin
              state_r <= ST_FIN;
            end else begin
              sel_r   <= sel_r + 1'b1;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_PIX;
        end
        default: state_r <= ST_PIX;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dfac_dp.sv =====
module dfac_dp #(
  parameter int unsigned BOX_SIZE        = dfac_pkg::BoxSizeDef,
  parameter int unsigned BOX_OFFSET      = dfac_pkg::BoxOffsetDef,
  parameter int unsigned CENTER_BOX_SIZE = dfac_pkg::CenterBoxSizeDef,
  parameter int unsigned COORD_WIDTH     = dfac_pkg::CoordWidthDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [dfac_pkg::CfgW-1:0]         cfg_data,
  input  logic [dfac_pkg::DepW-1:0]         in_depth,
  input  dfac_pkg::dfac_cmd_t               cmd,
  output dfac_pkg::dfac_sts_t               sts,
  output logic signed [dfac_pkg::DispW-1:0] out_horizontal_disparity,
  output logic signed [dfac_pkg::DispW-1:0] out_vertical_disparity,
  output logic                              out_aligned,
  output logic [dfac_pkg::DepW-1:0]         out_center_distance,
  output logic                              out_at_distance
);
  import dfac_pkg::*;

  localparam int  Half  = BOX_SIZE / 2;
  localparam int  CHalf = CENTER_BOX_SIZE / 2;
  localparam int  PW    = 15; // signed position width, covers -16384..16383
  localparam logic [COORD_WIDTH-1:0] CoordMax = '1;

  // configuration registers
  logic [DimW-1:0] frame_width_r, frame_height_r;
  logic [CfgW-1:0] min_depth_r, thr_r, target_r, tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DimW'(640);
      frame_height_r <= DimW'(480);
      min_depth_r    <= CfgW'(1);
      thr_r          <= CfgW'(10);
      target_r       <= '0;
      tol_r          <= CfgW'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFrameWidth:  frame_width_r  <= cfg_data[DimW-1:0];
        RegFrameHeight: frame_height_r <= cfg_data[DimW-1:0];
        RegMinDepth:    min_depth_r    <= cfg_data;
        RegOrientThr:   thr_r          <= cfg_data;
        RegDistTarget:  target_r       <= cfg_data;
        RegDistTol:     tol_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position
  logic [COORD_WIDTH-1:0] col_r, row_r;
  logic [COORD_WIDTH:0]   col_inc;
  assign col_inc = {1'b0, col_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.pix_en) begin
      if ({{(DimW-COORD_WIDTH+1){1'b0}}, col_inc} >= {2'b0, frame_width_r}
          || col_r == CoordMax) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_inc[COORD_WIDTH-1:0];
      end
    end
  end

  // box membership
  logic signed [PW-1:0] c_s, r_s, mc, mr;
  assign c_s = PW'(signed'({1'b0, col_r}));
  assign r_s = PW'(signed'({1'b0, row_r}));
  assign mc  = PW'(signed'({1'b0, frame_width_r[DimW-1:1]}));
  assign mr  = PW'(signed'({1'b0, frame_height_r[DimW-1:1]}));

  function automatic logic in_box(input logic signed [PW-1:0] c, r, cc, cr,
                                  input int h);
    logic signed [PW-1:0] hh;
    hh = PW'(h);
    return (r >= cr - hh) && (r <= cr + hh) && (c >= cc - hh) && (c < cc + hh);
  endfunction

  logic [NumAcc-1:0] hit;
  logic signed [PW-1:0] off;
  assign off = PW'(BOX_OFFSET);
  always_comb begin
    hit[AccUpper]  = in_box(c_s, r_s, mc, mr - off, Half);
    hit[AccLower]  = in_box(c_s, r_s, mc, mr + off, Half);
    hit[AccLeft]   = in_box(c_s, r_s, mc - off, mr, Half);
    hit[AccRight]  = in_box(c_s, r_s, mc + off, mr, Half);
    hit[AccCenter] = in_box(c_s, r_s, mc, mr, CHalf);
  end

  // accumulators with saturation
  logic [SumW-1:0] sum_r [NumAcc];
  logic [CntW-1:0] cnt_r [NumAcc];
  logic            valid_pix;
  assign valid_pix = in_depth >= min_depth_r;

  for (genvar g = 0; g < NumAcc; g++) begin : g_acc
    logic [SumW:0] s_nxt;
    assign s_nxt = {1'b0, sum_r[g]} + (SumW+1)'(in_depth);
    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clear) begin
        sum_r[g] <= '0;
        cnt_r[g] <= CntW'(1);
      end else if (cmd.pix_en && valid_pix && hit[g]) begin
        sum_r[g] <= s_nxt[SumW] ? '1 : s_nxt[SumW-1:0];
        if (cnt_r[g] != '1) cnt_r[g] <= cnt_r[g] + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit a cycle: (sum<<8)/cnt
  logic [QuoW-1:0] quo_r;
  logic [CntW:0]   rem_r;
  logic [CntW-1:0] dsr_r;
  logic [5:0]      step_r;
  logic [CntW+1:0] trial;
  logic            sh_in;
  assign sh_in = quo_r[QuoW-1];
  assign trial = {rem_r, sh_in} - {2'b0, dsr_r};
  assign sts.div_done = (step_r == 6'(QuoW));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= {sum_r[cmd.div_sel], 8'd0};
      rem_r  <= '0;
      dsr_r  <= cnt_r[cmd.div_sel];
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
      if (!trial[CntW+1]) begin
        rem_r <= trial[CntW:0];
        quo_r <= {quo_r[QuoW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CntW-1:0], sh_in};
        quo_r <= {quo_r[QuoW-2:0], 1'b0};
      end
    end
  end

  // clamped averages
  logic [AvgW-1:0] avg_r [NumAcc];
  logic [AvgW-1:0] avg_cl;
  assign avg_cl = (|quo_r[QuoW-1:AvgW]) ? '1 : quo_r[AvgW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.avg_store) avg_r[cmd.div_sel] <= avg_cl;
  end

  // disparities truncated toward zero
  function automatic logic signed [DispW-1:0] trunc_diff(input logic [AvgW-1:0] a, b);
    logic signed [AvgW:0] d;
    logic [AvgW:0] m;
    logic [DispW-1:0] q;
    d = signed'({1'b0, a}) - signed'({1'b0, b});
    m = d[AvgW] ? (AvgW+1)'(-d) : (AvgW+1)'(d);
    q = DispW'(m >> 8);
    return d[AvgW] ? signed'(-q) : signed'(q);
  endfunction

  logic signed [DispW-1:0] hd, vd, thr_p, thr_n;
  logic [DepW-1:0]         cd;
  logic signed [DepW+1:0]  err;
  logic [DepW:0]           err_abs;
  assign hd    = trunc_diff(avg_r[AccLeft], avg_r[AccRight]);
  assign vd    = trunc_diff(avg_r[AccUpper], avg_r[AccLower]);
  assign thr_p = signed'({1'b0, thr_r});
  assign thr_n = -thr_p;
  // integer part of the clamped centre average
  assign cd    = avg_r[AccCenter][AvgW-1:8];
  assign err   = signed'({2'b0, cd}) - signed'({2'b0, target_r});
  assign err_abs = err[DepW+1] ? (DepW+1)'(-err) : (DepW+1)'(err);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_horizontal_disparity <= hd;
      out_vertical_disparity   <= vd;
      out_aligned     <= (hd < thr_p) && (hd > thr_n) && (vd < thr_p) && (vd > thr_n);
      out_center_distance <= cd;
      out_at_distance <= err_abs <= {1'b0, tol_r};
    end
  end

endmodule

// ===== hw/rtl/dfac_checker.sv =====
module dfac_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last_of_frame,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dfac_pkg::DispW-1:0] out_horizontal_disparity,
  input logic                              out_aligned
);
  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_horizontal_disparity))
    else $error("result changed under stall");

  // frame end closes the input for the divide
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_of_frame |=> !in_ready)
    else $error("input open after frame end");

  // aligned implies small horizontal disparity magnitude is representable
  a_align_hd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aligned |-> out_horizontal_disparity != -17'sd65536)
    else $error("aligned with impossible disparity");

  // no input while a stalled result blocks
  a_no_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken under output stall");
endmodule

bind depth_frame_alignment_checker dfac_checker u_dfac_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_last_of_frame, .out_valid, .out_ready,
  .out_horizontal_disparity, .out_aligned
);
